// ----- src/http_chunked_body_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Property forms used by the chunked body parser.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Phase encoding, framing characters, result record and hex digit decode.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_EXT     = 3'd1,
        PH_SIZE_LF = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATA_CR = 3'd4,
        PH_DATA_LF = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    localparam int unsigned DIGIT_CNT_W = 4;
    localparam logic [DIGIT_CNT_W-1:0] DIGIT_CNT_MAX = '1;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload;
        logic       body_end;
        logic       format_error;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

// ----- src/hcbd_parser.sv -----
// ----------------------------------------------------------------------------
// Chunked body parser
// Holds the framing state and turns one body byte into at most one result.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_macros.svh"

module hcbd_parser
    import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_new,
    output t_result    o_res
);

    t_phase                 r_phase, n_phase;
    logic [SIZE_BITS-1:0]   r_rem, n_rem;
    logic [DIGIT_CNT_W-1:0] r_cnt, n_cnt;

    t_phase                 eff_phase;
    logic [SIZE_BITS-1:0]   eff_rem;
    logic [SIZE_BITS-1:0]   rem_dec;
    logic [DIGIT_CNT_W-1:0] eff_cnt;
    t_hex                   hex;
    t_result                res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        eff_phase = i_new ? PH_SIZE : r_phase;
        eff_rem   = i_new ? '0 : r_rem;
        eff_cnt   = i_new ? '0 : r_cnt;
        hex       = hex_decode(i_byte);
        rem_dec   = eff_rem - SIZE_BITS'(1);
        n_phase   = r_phase;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        res       = '0;
        if (i_en) begin
            n_phase = eff_phase;
            n_rem   = eff_rem;
            n_cnt   = eff_cnt;
            unique case (eff_phase)
                PH_SIZE: begin
                    if (hex.ok) begin
                        if (eff_rem[SIZE_BITS-1 -: 4] != 4'd0) begin
                            n_phase          = PH_ERROR;
                            res.valid        = 1'b1;
                            res.format_error = 1'b1;
                        end else begin
                            n_rem = {eff_rem[SIZE_BITS-5:0], hex.val};
                            if (eff_cnt != DIGIT_CNT_MAX) begin
                                n_cnt = eff_cnt + DIGIT_CNT_W'(1);
                            end
                        end
                    end else if (eff_cnt != '0 &&
                                 (i_byte == CH_SEMI || i_byte == CH_SP ||
                                  i_byte == CH_TAB)) begin
                        n_phase = PH_EXT;
                    end else if (eff_cnt != '0 && i_byte == CH_CR) begin
                        n_phase = PH_SIZE_LF;
                    end else begin
                        n_phase          = PH_ERROR;
                        res.valid        = 1'b1;
                        res.format_error = 1'b1;
                    end
                end
                PH_EXT: begin
                    if (i_byte == CH_CR) begin
                        n_phase = PH_SIZE_LF;
                    end
                end
                PH_SIZE_LF: begin
                    if (i_byte != CH_LF) begin
                        n_phase          = PH_ERROR;
                        res.valid        = 1'b1;
                        res.format_error = 1'b1;
                    end else if (eff_rem == '0) begin
                        n_phase      = PH_DONE;
                        res.valid    = 1'b1;
                        res.body_end = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_rem       = rem_dec;
                    res.valid   = 1'b1;
                    res.payload = i_byte;
                    if (rem_dec == '0) begin
                        n_phase = PH_DATA_CR;
                    end
                end
                PH_DATA_CR: begin
                    if (i_byte != CH_CR) begin
                        n_phase          = PH_ERROR;
                        res.valid        = 1'b1;
                        res.format_error = 1'b1;
                    end else begin
                        n_phase = PH_DATA_LF;
                    end
                end
                PH_DATA_LF: begin
                    if (i_byte != CH_LF) begin
                        n_phase          = PH_ERROR;
                        res.valid        = 1'b1;
                        res.format_error = 1'b1;
                    end else begin
                        n_phase = PH_SIZE;
                        n_rem   = '0;
                        n_cnt   = '0;
                    end
                end
                PH_DONE: begin
                end
                PH_ERROR: begin
                    res.valid        = 1'b1;
                    res.format_error = 1'b1;
                end
            endcase
        end
    end

    assign o_res = res;

    `HCBD_ASSERT_SAME(a_end_err_excl, i_clk, i_rst_n, res.valid,
        !(res.body_end && res.format_error), "end and error flagged together")
    `HCBD_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n,
        r_phase == PH_ERROR && !(i_en && i_new), r_phase == PH_ERROR,
        "error state left without a new body")
    `HCBD_ASSERT_SAME(a_data_emits, i_clk, i_rst_n, i_en && !i_new && r_phase == PH_DATA,
        res.valid && !res.body_end && !res.format_error, "payload byte produced no result")
    `HCBD_ASSERT_SAME(a_data_nonzero, i_clk, i_rst_n, r_phase == PH_DATA, r_rem != '0,
        "payload phase with no bytes left")

endmodule

// ----- src/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Input register, chunk framing parser and registered result stage.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per clock cycle while the result side is
// not stalled, and returns each payload byte, a body end marker or an error
// marker through the input register and then the result register.
// The result register decouples the two sides, so an empty input register
// takes a new byte while a finished result still waits for the downstream ready.

module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] body_byte
    input  logic       s_axis_tuser,   // [0] new_body
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [1:0] m_axis_tuser    // [0] body_end, [1] format_error
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new;
    logic       r_out_valid;
    logic [7:0] r_out_payload;
    logic       r_out_end;
    logic       r_out_err;
    logic       advance;
    logic       in_take;
    t_result    res;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_new  <= s_axis_tuser;
        end
    end

    hcbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && advance),
        .i_byte  (r_in_byte),
        .i_new   (r_in_new),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out_payload <= res.payload;
            r_out_end     <= res.body_end;
            r_out_err     <= res.format_error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_payload;
    assign m_axis_tuser  = {r_out_err, r_out_end};

endmodule
